// ===== hw/rtl/jbs_pkg.sv =====
package jbs_pkg;

    // width of the bracket nesting counter
    localparam int unsigned DepthBits = 16;

    // verdict codes
    localparam logic [1:0] VerdictScan   = 2'd0;
    localparam logic [1:0] VerdictAccept = 2'd1;
    localparam logic [1:0] VerdictReject = 2'd2;

    // byte characters that matter to the scan
    localparam logic [7:0] ChLBrace = 8'h7B;
    localparam logic [7:0] ChLBrack = 8'h5B;
    localparam logic [7:0] ChRBrace = 8'h7D;
    localparam logic [7:0] ChRBrack = 8'h5D;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBSlash = 8'h5C;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChCr     = 8'h0D;

    // byte class as decided by the front
    typedef enum logic [2:0] {
        CL_OTHER   = 3'd0,
        CL_SPACE   = 3'd1,
        CL_LBRACE  = 3'd2,
        CL_LBRACK  = 3'd3,
        CL_RBRACE  = 3'd4,
        CL_RBRACK  = 3'd5,
        CL_QUOTE   = 3'd6,
        CL_BSLASH  = 3'd7
    } t_cls;

    // classified word passed from front to back
    typedef struct packed {
        logic begin_scan;
        logic json_wanted;
        logic end_of_input;
        t_cls cls;
    } t_word;

    // scan phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LEAD = 4'b0010,
        PH_OPEN = 4'b0100,
        PH_BODY = 4'b1000
    } t_phase;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r = CL_OTHER;
        if (c == ChSpace || c == ChTab || c == ChLf || c == ChCr) r = CL_SPACE;
        else if (c == ChLBrace) r = CL_LBRACE;
        else if (c == ChLBrack) r = CL_LBRACK;
        else if (c == ChRBrace) r = CL_RBRACE;
        else if (c == ChRBrack) r = CL_RBRACK;
        else if (c == ChQuote)  r = CL_QUOTE;
        else if (c == ChBSlash) r = CL_BSLASH;
        return r;
    endfunction

endpackage

// ===== hw/rtl/json_block_bracket_scanner_unit.sv =====
// JSON block bracket scanner.
// Input channel: i_valid / o_stall with i_begin_scan, i_json_wanted,
// i_char_in and i_end_of_input; a word is taken at a rising edge with
// i_valid high and o_stall low. Output channel: o_valid / i_stall with
// o_verdict (0 scanning, 1 accepted, 2 rejected) and o_in_token, one
// result word for every input word, in order.
// The front registers and classifies each byte, a two-word queue decouples
// it from the back, which runs the scan state and holds the result in an
// output register. A word passes the front register, the queue and the
// output register in that order; throughput is one word per cycle while
// the receiver does not stall.
// Reset (synchronous, active low) empties the front register, the queue and
// the output register and returns the scan to idle.
// When the receiver stalls, the result holds steady; the queue and front
// register keep taking words until three are buffered, then o_stall rises.
module json_block_bracket_scanner_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_begin_scan,
    input  logic       i_json_wanted,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_verdict,
    output logic       o_in_token
);

    logic           f_valid;
    jbs_pkg::t_word f_word;
    logic           q_full;
    logic           q_nonempty;
    jbs_pkg::t_word q_word;
    logic           q_pop;

    // front: accept and classify
    jbs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_begin_scan   (i_begin_scan),
        .i_json_wanted  (i_json_wanted),
        .i_char_in      (i_char_in),
        .i_end_of_input (i_end_of_input),
        .o_word_valid   (f_valid),
        .i_word_full    (q_full),
        .o_word         (f_word)
    );

    // queue between front and back
    jbs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_valid),
        .i_word     (f_word),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_word     (q_word)
    );

    // back: scan state and result
    jbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (q_nonempty),
        .i_word       (q_word),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_verdict    (o_verdict),
        .o_in_token   (o_in_token)
    );

endmodule

// ===== hw/rtl/jbs_front.sv =====
module jbs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_begin_scan,
    input  logic              i_json_wanted,
    input  logic [7:0]        i_char_in,
    input  logic              i_end_of_input,
    output logic              o_word_valid,
    input  logic              i_word_full,
    output jbs_pkg::t_word    o_word
);

    logic           r_valid;
    logic           n_valid;
    jbs_pkg::t_word r_word;
    logic           take;
    logic           moved;

    // the held word moves on whenever the queue has room
    assign moved   = r_valid && !i_word_full;
    assign o_stall = r_valid && i_word_full;
    assign take    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (take) n_valid = 1'b1;
        else if (moved) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // classify the byte on acceptance
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word.begin_scan   <= i_begin_scan;
            r_word.json_wanted  <= i_json_wanted;
            r_word.end_of_input <= i_end_of_input;
            r_word.cls          <= jbs_pkg::classify(i_char_in);
        end
    end

    assign o_word_valid = r_valid;
    assign o_word       = r_word;

endmodule

// ===== hw/rtl/jbs_queue.sv =====
module jbs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jbs_pkg::t_word i_word,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output jbs_pkg::t_word o_word
);

    jbs_pkg::t_word r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_word     = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop) r_rd <= ~r_rd;
            if (do_push && !do_pop) r_count <= r_count + 2'd1;
            else if (do_pop && !do_push) r_count <= r_count - 2'd1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_word;
    end

endmodule

// ===== hw/rtl/jbs_back.sv =====
module jbs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_word_valid,
    input  jbs_pkg::t_word i_word,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [1:0]     o_verdict,
    output logic           o_in_token
);

    localparam logic [jbs_pkg::DepthBits-1:0] DepthMax = '1;
    localparam logic [jbs_pkg::DepthBits-1:0] DepthOne =
        jbs_pkg::DepthBits'(1);

    jbs_pkg::t_phase               r_phase, n_phase;
    logic                          r_brace, n_brace;
    logic [jbs_pkg::DepthBits-1:0] r_depth, n_depth;
    logic                          r_str, n_str;
    logic                          r_esc, n_esc;
    logic                          r_out_valid;
    logic [1:0]                    r_verdict, n_verdict;
    logic                          r_tok, n_tok;
    jbs_pkg::t_phase               ph;
    logic                          body;
    logic                          open_ok;

    // take a word when the output register is free or being emptied
    assign o_pop = i_word_valid && (!r_out_valid || !i_stall);

    // opening check of the first non-blank byte after the bracket
    always_comb begin
        if (r_brace) begin
            open_ok = (i_word.cls == jbs_pkg::CL_QUOTE) ||
                      (i_word.cls == jbs_pkg::CL_RBRACE);
        end else begin
            open_ok = (i_word.cls == jbs_pkg::CL_LBRACE) ||
                      (i_word.cls == jbs_pkg::CL_LBRACK) ||
                      (i_word.cls == jbs_pkg::CL_QUOTE) ||
                      (i_word.cls == jbs_pkg::CL_RBRACK);
        end
    end

    // scan step for one word
    always_comb begin
        n_phase   = r_phase;
        n_brace   = r_brace;
        n_depth   = r_depth;
        n_str     = r_str;
        n_esc     = r_esc;
        n_verdict = jbs_pkg::VerdictScan;
        n_tok     = 1'b0;
        body      = 1'b0;
        ph        = r_phase;
        if (i_word.begin_scan) begin
            n_brace = 1'b0;
            n_depth = '0;
            n_str   = 1'b0;
            n_esc   = 1'b0;
            ph      = i_word.json_wanted ? jbs_pkg::PH_LEAD : jbs_pkg::PH_IDLE;
            n_phase = ph;
            if (!i_word.json_wanted) n_verdict = jbs_pkg::VerdictReject;
        end
        if (i_word.end_of_input && ph != jbs_pkg::PH_IDLE) begin
            n_verdict = jbs_pkg::VerdictReject;
            n_phase   = jbs_pkg::PH_IDLE;
        end else begin
            unique case (ph)
                jbs_pkg::PH_IDLE: begin
                end
                jbs_pkg::PH_LEAD: begin
                    if (i_word.cls == jbs_pkg::CL_SPACE) begin
                        n_tok = 1'b0;
                    end else if (i_word.cls == jbs_pkg::CL_LBRACE ||
                                 i_word.cls == jbs_pkg::CL_LBRACK) begin
                        n_brace = (i_word.cls == jbs_pkg::CL_LBRACE);
                        n_phase = jbs_pkg::PH_OPEN;
                        n_tok   = 1'b1;
                    end else begin
                        n_verdict = jbs_pkg::VerdictReject;
                        n_phase   = jbs_pkg::PH_IDLE;
                    end
                end
                jbs_pkg::PH_OPEN: begin
                    if (i_word.cls == jbs_pkg::CL_SPACE) begin
                        n_tok = 1'b1;
                    end else if (!open_ok) begin
                        n_verdict = jbs_pkg::VerdictReject;
                        n_phase   = jbs_pkg::PH_IDLE;
                    end else begin
                        n_phase = jbs_pkg::PH_BODY;
                        n_depth = DepthOne;
                        n_str   = 1'b0;
                        n_esc   = 1'b0;
                        body    = 1'b1;
                    end
                end
                jbs_pkg::PH_BODY: begin
                    body = 1'b1;
                end
                default: begin
                    n_phase = jbs_pkg::PH_IDLE;
                end
            endcase
        end
        // body byte: strings, escapes and bracket depth
        if (body) begin
            n_tok = 1'b1;
            if (n_esc) begin
                n_esc = 1'b0;
            end else if (n_str) begin
                if (i_word.cls == jbs_pkg::CL_BSLASH) n_esc = 1'b1;
                else if (i_word.cls == jbs_pkg::CL_QUOTE) n_str = 1'b0;
            end else if (i_word.cls == jbs_pkg::CL_QUOTE) begin
                n_str = 1'b1;
            end else if (i_word.cls == jbs_pkg::CL_LBRACE ||
                         i_word.cls == jbs_pkg::CL_LBRACK) begin
                if (n_depth == DepthMax) begin
                    n_verdict = jbs_pkg::VerdictReject;
                    n_tok     = 1'b0;
                    n_phase   = jbs_pkg::PH_IDLE;
                end else begin
                    n_depth = n_depth + DepthOne;
                end
            end else if (i_word.cls == jbs_pkg::CL_RBRACE ||
                         i_word.cls == jbs_pkg::CL_RBRACK) begin
                n_depth = n_depth - DepthOne;
                if (n_depth == '0) begin
                    n_verdict = jbs_pkg::VerdictAccept;
                    n_phase   = jbs_pkg::PH_IDLE;
                end
            end
        end
    end

    // scan state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jbs_pkg::PH_IDLE;
            r_brace     <= 1'b0;
            r_depth     <= '0;
            r_str       <= 1'b0;
            r_esc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_brace <= n_brace;
                r_depth <= n_depth;
                r_str   <= n_str;
                r_esc   <= n_esc;
            end
            if (o_pop) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_verdict <= n_verdict;
            r_tok     <= n_tok;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_verdict  = r_verdict;
    assign o_in_token = r_tok;

endmodule

// ===== dv/json_block_bracket_scanner_unit_tb.sv =====
`timescale 1ns / 100ps

module json_block_bracket_scanner_unit_tb;

    localparam int CycleLimit = 1_000_000;
    localparam int ReportLimit = 10;

    // bytes with no meaning to the scan
    localparam logic [7:0] ChPlainA = 8'h61;
    localparam logic [7:0] ChColon  = 8'h3A;

    // one input word and one result word
    typedef struct packed {
        logic       begin_scan;
        logic       json_wanted;
        logic [7:0] ch;
        logic       eoi;
    } t_scan_in;

    typedef struct packed {
        logic [1:0] verdict;
        logic       in_token;
    } t_scan_out;

    // tracks the scan state and holds the verdicts still owed by the block
    class t_bracket_board;
        jbs_pkg::t_phase              phase;
        logic                         brace_open;
        logic [jbs_pkg::DepthBits-1:0] depth;
        logic                         in_str;
        logic                         escaped;
        t_scan_out                    due_words[$];
        int                           errors;
        int                           mismatches;

        function new();
            phase      = jbs_pkg::PH_IDLE;
            brace_open = 1'b0;
            depth      = '0;
            in_str     = 1'b0;
            escaped    = 1'b0;
            errors     = 0;
            mismatches = 0;
        endfunction

        function logic is_blank(logic [7:0] c);
            return c == jbs_pkg::ChSpace || c == jbs_pkg::ChTab ||
                   c == jbs_pkg::ChLf || c == jbs_pkg::ChCr;
        endfunction

        // one byte inside the block: strings, escapes and nesting
        function t_scan_out body_step(logic [7:0] c);
            t_scan_out r;
            r.verdict  = jbs_pkg::VerdictScan;
            r.in_token = 1'b1;
            if (escaped) begin
                escaped = 1'b0;
            end else if (in_str) begin
                if (c == jbs_pkg::ChBSlash) begin
                    escaped = 1'b1;
                end else if (c == jbs_pkg::ChQuote) begin
                    in_str = 1'b0;
                end
            end else if (c == jbs_pkg::ChQuote) begin
                in_str = 1'b1;
            end else if (c == jbs_pkg::ChLBrace || c == jbs_pkg::ChLBrack) begin
                if (depth == '1) begin
                    r.verdict  = jbs_pkg::VerdictReject;
                    r.in_token = 1'b0;
                end else begin
                    depth++;
                end
            end else if (c == jbs_pkg::ChRBrace || c == jbs_pkg::ChRBrack) begin
                depth--;
                if (depth == '0) begin
                    r.verdict = jbs_pkg::VerdictAccept;
                end
            end
            return r;
        endfunction

        // accepted input word: advance the scan and queue its verdict
        function void note_word(t_scan_in w);
            t_scan_out r;
            logic      first_ok;
            r.verdict  = jbs_pkg::VerdictScan;
            r.in_token = 1'b0;
            if (w.begin_scan) begin
                brace_open = 1'b0;
                depth      = '0;
                in_str     = 1'b0;
                escaped    = 1'b0;
                if (w.json_wanted) begin
                    phase = jbs_pkg::PH_LEAD;
                end else begin
                    phase = jbs_pkg::PH_IDLE;
                end
            end
            if (w.begin_scan && !w.json_wanted) begin
                r.verdict = jbs_pkg::VerdictReject;
            end else if (phase != jbs_pkg::PH_IDLE) begin
                if (w.eoi) begin
                    r.verdict = jbs_pkg::VerdictReject;
                end else begin
                    case (phase)
                        jbs_pkg::PH_LEAD: begin
                            if (w.ch == jbs_pkg::ChLBrace || w.ch == jbs_pkg::ChLBrack) begin
                                brace_open = (w.ch == jbs_pkg::ChLBrace);
                                phase      = jbs_pkg::PH_OPEN;
                                r.in_token = 1'b1;
                            end else if (!is_blank(w.ch)) begin
                                r.verdict = jbs_pkg::VerdictReject;
                            end
                        end
                        jbs_pkg::PH_OPEN: begin
                            if (brace_open) begin
                                first_ok = (w.ch == jbs_pkg::ChQuote ||
                                            w.ch == jbs_pkg::ChRBrace);
                            end else begin
                                first_ok = (w.ch == jbs_pkg::ChLBrace ||
                                            w.ch == jbs_pkg::ChLBrack ||
                                            w.ch == jbs_pkg::ChQuote ||
                                            w.ch == jbs_pkg::ChRBrack);
                            end
                            if (is_blank(w.ch)) begin
                                r.in_token = 1'b1;
                            end else if (first_ok) begin
                                phase   = jbs_pkg::PH_BODY;
                                depth   = jbs_pkg::DepthBits'(1);
                                in_str  = 1'b0;
                                escaped = 1'b0;
                                r       = body_step(w.ch);
                            end else begin
                                r.verdict = jbs_pkg::VerdictReject;
                            end
                        end
                        default: begin
                            r = body_step(w.ch);
                        end
                    endcase
                end
            end
            if (r.verdict != jbs_pkg::VerdictScan) begin
                phase = jbs_pkg::PH_IDLE;
            end
            due_words.push_back(r);
        endfunction

        // accepted result word against the oldest owed verdict
        function void check_word(logic [1:0] v, logic t);
            t_scan_out exp_w;
            if (due_words.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= ReportLimit) begin
                    $display("unexpected result word: verdict %0d in_token %0d", v, t);
                end
                return;
            end
            exp_w = due_words.pop_front();
            if (v !== exp_w.verdict || t !== exp_w.in_token) begin
                errors++;
                mismatches++;
                if (mismatches <= ReportLimit) begin
                    $display({"result mismatch: verdict exp %0d got %0d, ",
                              "in_token exp %0d got %0d"},
                             exp_w.verdict, v, exp_w.in_token, t);
                end
            end
        endfunction

        function void close_out();
            if (due_words.size() != 0) begin
                errors++;
                $display("%0d result words never arrived", due_words.size());
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_begin_scan;
    logic       i_json_wanted;
    logic [7:0] i_char_in;
    logic       i_end_of_input;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_verdict;
    logic       o_in_token;

    t_bracket_board board;
    t_scan_in       plan[$];
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    int             cycle_count = 0;

    json_block_bracket_scanner_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_begin_scan   (i_begin_scan),
        .i_json_wanted  (i_json_wanted),
        .i_char_in      (i_char_in),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_verdict      (o_verdict),
        .o_in_token     (o_in_token)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("json_block_bracket_scanner_unit_tb: FAIL");
            $finish;
        end
    end

    // receiver stall
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_word(o_verdict, o_in_token);
        end
    end

    function automatic void add_item(input logic b, input logic w, input logic [7:0] c,
                                     input logic e);
        t_scan_in it;
        it.begin_scan  = b;
        it.json_wanted = w;
        it.ch          = c;
        it.eoi         = e;
        plan.push_back(it);
    endfunction

    // a plain byte word, wanted flag is don't-care here
    function automatic void add_text(input logic [7:0] c);
        add_item(1'b0, 1'($urandom_range(1)), c, 1'b0);
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return jbs_pkg::ChSpace;
            1: return jbs_pkg::ChTab;
            2: return jbs_pkg::ChLf;
            default: return jbs_pkg::ChCr;
        endcase
    endfunction

    function automatic logic [7:0] pick_open();
        return $urandom_range(1) ? jbs_pkg::ChLBrace : jbs_pkg::ChLBrack;
    endfunction

    function automatic logic [7:0] pick_close();
        return $urandom_range(1) ? jbs_pkg::ChRBrace : jbs_pkg::ChRBrack;
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == jbs_pkg::ChLBrace || c == jbs_pkg::ChLBrack ||
                   c == jbs_pkg::ChRBrace || c == jbs_pkg::ChRBrack ||
                   c == jbs_pkg::ChQuote || c == jbs_pkg::ChBSlash ||
                   c == jbs_pkg::ChSpace || c == jbs_pkg::ChTab ||
                   c == jbs_pkg::ChLf || c == jbs_pkg::ChCr);
        return c;
    endfunction

    // quoted string with random bytes, some escaped
    function automatic void add_string();
        logic [7:0] c;
        add_text(jbs_pkg::ChQuote);
        repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(255));
            if (c == jbs_pkg::ChQuote || c == jbs_pkg::ChBSlash ||
                $urandom_range(7) == 0) begin
                add_text(jbs_pkg::ChBSlash);
            end
            add_text(c);
        end
        add_text(jbs_pkg::ChQuote);
    endfunction

    // mostly well-formed block, one in five broken on purpose
    function automatic void plan_block();
        int         lvl;
        int         steps;
        int         k;
        logic [7:0] opener;
        repeat ($urandom_range(0, 2)) add_text(pick_blank());
        opener = pick_open();
        add_text(opener);
        plan[0].begin_scan  = 1'b1;
        plan[0].json_wanted = 1'b1;
        if ($urandom_range(1)) begin
            add_text(pick_blank());
        end
        lvl = 1;
        if (opener == jbs_pkg::ChLBrace) begin
            if ($urandom_range(4) == 0) begin
                add_text(jbs_pkg::ChRBrace);
                lvl = 0;
            end else begin
                add_string();
            end
        end else begin
            case ($urandom_range(3))
                0, 1: begin
                    add_text(pick_open());
                    lvl++;
                end
                2: add_string();
                default: begin
                    add_text(jbs_pkg::ChRBrack);
                    lvl = 0;
                end
            endcase
        end
        steps = $urandom_range(0, 24);
        while (lvl > 0) begin
            if (steps == 0) begin
                add_text(pick_close());
                lvl--;
            end else begin
                steps--;
                case ($urandom_range(5))
                    0: begin
                        if (lvl < 8) begin
                            add_text(pick_open());
                            lvl++;
                        end
                    end
                    1: begin
                        add_text(pick_close());
                        lvl--;
                    end
                    2: add_string();
                    3: add_text(pick_blank());
                    default: add_text(pick_plain());
                endcase
            end
        end
        if ($urandom_range(4) == 0) begin
            k = $urandom_range(0, plan.size() - 1);
            case ($urandom_range(3))
                0: plan[k].ch = 8'($urandom_range(255));
                1: begin
                    // input ends early
                    while (plan.size() > k + 1) void'(plan.pop_back());
                    plan[k].eoi = 1'b1;
                    plan[k].ch  = 8'($urandom_range(255));
                end
                2: plan[0].json_wanted = 1'b0;
                default: begin
                    // restart in the middle of the block
                    plan[k].begin_scan  = 1'b1;
                    plan[k].json_wanted = 1'($urandom_range(1));
                end
            endcase
        end
    endfunction

    // directed words: idle, whitespace, strings, escapes, reject paths but the depth limit
    function automatic void plan_directed();
        add_item(1'b0, 1'b1, ChPlainA, 1'b0);
        add_item(1'b0, 1'b0, 8'hFF, 1'b1);
        add_item(1'b1, 1'b0, jbs_pkg::ChLBrace, 1'b0);
        add_item(1'b1, 1'b1, jbs_pkg::ChSpace, 1'b0);
        add_text(jbs_pkg::ChTab);
        add_text(jbs_pkg::ChCr);
        add_text(jbs_pkg::ChLf);
        add_text(jbs_pkg::ChLBrace);
        add_text(jbs_pkg::ChSpace);
        add_text(jbs_pkg::ChQuote);
        add_text(jbs_pkg::ChBSlash);
        add_text(jbs_pkg::ChQuote);
        add_text(jbs_pkg::ChRBrace);
        add_text(jbs_pkg::ChQuote);
        add_text(ChColon);
        add_text(jbs_pkg::ChRBrace);
        add_text(jbs_pkg::ChRBrace);
        add_item(1'b1, 1'b1, jbs_pkg::ChLBrack, 1'b0);
        add_text(jbs_pkg::ChRBrack);
        add_item(1'b1, 1'b1, ChPlainA, 1'b0);
        add_item(1'b1, 1'b1, jbs_pkg::ChLBrack, 1'b0);
        add_text(ChPlainA);
        add_item(1'b1, 1'b1, jbs_pkg::ChLBrace, 1'b0);
        add_text(jbs_pkg::ChLBrack);
        add_item(1'b1, 1'b1, jbs_pkg::ChLBrack, 1'b0);
        add_text(jbs_pkg::ChLBrack);
        add_item(1'b1, 1'b1, jbs_pkg::ChLBrace, 1'b0);
        add_text(jbs_pkg::ChRBrace);
        add_item(1'b1, 1'b1, jbs_pkg::ChSpace, 1'b0);
        add_item(1'b0, 1'b1, 8'h00, 1'b1);
        add_item(1'b1, 1'b1, jbs_pkg::ChLBrack, 1'b1);
        add_item(1'b1, 1'b1, jbs_pkg::ChLBrack, 1'b0);
        add_text(jbs_pkg::ChQuote);
        add_text(8'hFF);
        add_text(8'h00);
        add_text(jbs_pkg::ChQuote);
        add_text(jbs_pkg::ChLBrack);
        add_item(1'b0, 1'b1, jbs_pkg::ChRBrack, 1'b1);
    endfunction

    // stray words between scans
    function automatic void plan_noise();
        repeat ($urandom_range(0, 2)) begin
            add_item(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)),
                     ($urandom_range(3) == 0));
        end
    endfunction

    task automatic push_word(input t_scan_in it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_begin_scan   <= it.begin_scan;
        i_json_wanted  <= it.json_wanted;
        i_char_in      <= it.ch;
        i_end_of_input <= it.eoi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_word(it);
    endtask

    task automatic drive_plan();
        for (int i = 0; i < plan.size(); i++) begin
            push_word(plan[i]);
        end
        plan.delete();
    endtask

    // sender holds off until every owed verdict is back
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.due_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        int sent;
        sent = 0;
        while (sent < n) begin
            plan_block();
            sent += plan.size();
            plan_noise();
            drive_plan();
        end
    endtask

    // reset, directed words, then random blocks under four idle mixes
    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_begin_scan   = 1'b0;
        i_json_wanted  = 1'b0;
        i_char_in      = 8'h00;
        i_end_of_input = 1'b0;
        i_stall        = 1'b0;
        board          = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan_directed();
        drive_plan();
        wait_drained();
        run_random(375);

        wait_drained();
        send_idle_pct = 63;
        stall_pct     = 0;
        run_random(375);

        wait_drained();
        send_idle_pct = 0;
        stall_pct     = 63;
        run_random(375);

        wait_drained();
        send_idle_pct = 17;
        stall_pct     = 17;
        run_random(375);

        wait_drained();
        repeat (8) @(posedge i_clk);
        board.close_out();
        if (board.errors == 0) begin
            $display("json_block_bracket_scanner_unit_tb: PASS");
        end else begin
            $display("json_block_bracket_scanner_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== json_block_bracket_scanner_unit.f =====
hw/rtl/jbs_pkg.sv
hw/rtl/jbs_front.sv
hw/rtl/jbs_queue.sv
hw/rtl/jbs_back.sv
hw/rtl/json_block_bracket_scanner_unit.sv
dv/json_block_bracket_scanner_unit_tb.sv
